### hw/rtl/mwuf_pkg.sv
`timescale 1ns / 1ps

package mwuf_pkg;

   localparam int MAX_ROWS    = 32;
   localparam int MAX_COLUMNS = 32;
   localparam int POINT_DEPTH = (MAX_ROWS + 1) * (MAX_COLUMNS + 1);
   localparam int EDGE_DEPTH  = 2 * MAX_ROWS * MAX_COLUMNS - MAX_ROWS - MAX_COLUMNS;
   localparam int SWEEP_LEN   = (POINT_DEPTH > EDGE_DEPTH) ? POINT_DEPTH : EDGE_DEPTH;

   localparam int SIZE_W  = 6;
   localparam int EDGE_W  = 11;
   localparam int PT_W    = $clog2(POINT_DEPTH);
   localparam int EDGE_AW = $clog2(EDGE_DEPTH);
   localparam int CNT_W   = $clog2(SWEEP_LEN);
   localparam int STEP_W  = $clog2(POINT_DEPTH + 1);
   localparam int DIVC_W  = $clog2(EDGE_W);
   localparam int RANK_W  = 4;

   localparam logic CSR_GRID_ROWS    = 1'b0;
   localparam logic CSR_GRID_COLUMNS = 1'b1;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_PINIT, ST_PRD, ST_PCHK, ST_MARK, ST_DIV,
      ST_ADDR1, ST_ADDR2, ST_RA_INIT, ST_RA_RD, ST_RA_CHK, ST_RB_INIT,
      ST_RB_RD, ST_RB_CHK, ST_CMP, ST_RKA, ST_RKB, ST_UNITE, ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      OUT_NONE, OUT_ZERO, OUT_ALL_USED, OUT_WALL
   } out_kind_type;

   typedef struct packed {
      logic         req_ready;
      logic         accept;
      logic         sweep_start;
      logic         sweep_step;
      logic         probe_init;
      logic         probe_step;
      logic         mark;
      logic         div_step;
      logic         addr1;
      logic         addr2;
      logic         root_init_a;
      logic         root_init_b;
      logic         root_step;
      logic         save_ra;
      logic         save_rb;
      logic         rank_sel_b;
      logic         save_rka;
      logic         unite;
      logic         load_out;
      out_kind_type out_kind;
   } cmd_type;

   typedef struct packed {
      logic req_func;
      logic sweep_last;
      logic probe_free;
      logic probe_exhausted;
      logic div_last;
      logic root_done;
      logic roots_equal;
      logic out_free;
   } status_type;

endpackage

### hw/rtl/mwuf_req_if.sv
`timescale 1ns / 1ps

interface mwuf_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [10:0] start_edge;
   logic        probe_down;

   modport source (output valid, func, start_edge, probe_down, input ready);
   modport sink (input valid, func, start_edge, probe_down, output ready);
endinterface

### hw/rtl/mwuf_rsp_if.sv
`timescale 1ns / 1ps

interface mwuf_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] edge_index;
   logic        is_vertical;
   logic [5:0]  wall_row;
   logic [5:0]  wall_col;
   logic        wall_built;
   logic        all_used;

   modport source (output valid, edge_index, is_vertical, wall_row, wall_col, wall_built,
                   all_used, input ready);
   modport sink (input valid, edge_index, is_vertical, wall_row, wall_col, wall_built,
                 all_used, output ready);
endinterface

### hw/rtl/mwuf_csr_if.sv
`timescale 1ns / 1ps

interface mwuf_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [5:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/maze_wall_union_find_unit.sv
`timescale 1ns / 1ps

// Find beat: probe the edge map from the start edge for a free edge, mark it, decode it
// with a bit-serial divide, walk both roots, then unite them unless the roots agree.
// Start beat: one clearing sweep over the edge map and point store.
// Flow: one beat at a time; a new beat is taken while the last result waits.
// Reset: synchronous, active high; then a clearing pass, no beat taken.
module maze_wall_union_find_unit (
   input logic        clock,
   input logic        reset,
   mwuf_req_if.sink   req_bus,
   mwuf_rsp_if.source rsp_bus,
   mwuf_csr_if.sink   csr_bus
);

   mwuf_pkg::cmd_type    cmd;
   mwuf_pkg::status_type status;

   // config writes always taken
   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = cmd.req_ready;

   // sequencer: probe loop, divide, two root walks, union
   mwuf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .status    (status),
      .cmd       (cmd)
   );

   // stores, divider, walk registers and result register
   mwuf_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req_bus.func),
      .req_start_edge  (req_bus.start_edge),
      .req_probe_down  (req_bus.probe_down),
      .csr_valid       (csr_bus.valid),
      .csr_index       (csr_bus.index),
      .csr_data        (csr_bus.data),
      .rsp_ready       (rsp_bus.ready),
      .rsp_valid       (rsp_bus.valid),
      .rsp_edge_index  (rsp_bus.edge_index),
      .rsp_is_vertical (rsp_bus.is_vertical),
      .rsp_wall_row    (rsp_bus.wall_row),
      .rsp_wall_col    (rsp_bus.wall_col),
      .rsp_wall_built  (rsp_bus.wall_built),
      .rsp_all_used    (rsp_bus.all_used)
   );

endmodule

### hw/rtl/mwuf_ctrl.sv
`timescale 1ns / 1ps

module mwuf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  mwuf_pkg::status_type status,
   output mwuf_pkg::cmd_type    cmd
);

   mwuf_pkg::state_type    state_ff, state_in;
   mwuf_pkg::out_kind_type kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mwuf_pkg::ST_CLEAR;
         kind_ff  <= mwuf_pkg::OUT_NONE;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      case (state_ff)
         mwuf_pkg::ST_CLEAR: begin
            if (status.sweep_last) begin
               state_in = (kind_ff == mwuf_pkg::OUT_NONE) ? mwuf_pkg::ST_IDLE
                                                          : mwuf_pkg::ST_DONE;
            end
         end
         mwuf_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (status.req_func) begin
                  state_in = mwuf_pkg::ST_PINIT;
               end else begin
                  state_in = mwuf_pkg::ST_CLEAR;
                  kind_in  = mwuf_pkg::OUT_ZERO;
               end
            end
         end
         mwuf_pkg::ST_PINIT: state_in = mwuf_pkg::ST_PRD;
         mwuf_pkg::ST_PRD:   state_in = mwuf_pkg::ST_PCHK;
         mwuf_pkg::ST_PCHK: begin
            if (status.probe_free) begin
               state_in = mwuf_pkg::ST_MARK;
            end else if (status.probe_exhausted) begin
               state_in = mwuf_pkg::ST_DONE;
               kind_in  = mwuf_pkg::OUT_ALL_USED;
            end else begin
               state_in = mwuf_pkg::ST_PRD;
            end
         end
         mwuf_pkg::ST_MARK: state_in = mwuf_pkg::ST_DIV;
         mwuf_pkg::ST_DIV: begin
            if (status.div_last) state_in = mwuf_pkg::ST_ADDR1;
         end
         mwuf_pkg::ST_ADDR1:   state_in = mwuf_pkg::ST_ADDR2;
         mwuf_pkg::ST_ADDR2:   state_in = mwuf_pkg::ST_RA_INIT;
         mwuf_pkg::ST_RA_INIT: state_in = mwuf_pkg::ST_RA_RD;
         mwuf_pkg::ST_RA_RD:   state_in = mwuf_pkg::ST_RA_CHK;
         mwuf_pkg::ST_RA_CHK: begin
            state_in = status.root_done ? mwuf_pkg::ST_RB_INIT : mwuf_pkg::ST_RA_RD;
         end
         mwuf_pkg::ST_RB_INIT: state_in = mwuf_pkg::ST_RB_RD;
         mwuf_pkg::ST_RB_RD:   state_in = mwuf_pkg::ST_RB_CHK;
         mwuf_pkg::ST_RB_CHK: begin
            state_in = status.root_done ? mwuf_pkg::ST_CMP : mwuf_pkg::ST_RB_RD;
         end
         mwuf_pkg::ST_CMP: begin
            kind_in  = mwuf_pkg::OUT_WALL;
            state_in = status.roots_equal ? mwuf_pkg::ST_DONE : mwuf_pkg::ST_RKA;
         end
         mwuf_pkg::ST_RKA:   state_in = mwuf_pkg::ST_RKB;
         mwuf_pkg::ST_RKB:   state_in = mwuf_pkg::ST_UNITE;
         mwuf_pkg::ST_UNITE: state_in = mwuf_pkg::ST_DONE;
         mwuf_pkg::ST_DONE: begin
            if (status.out_free) begin
               state_in = mwuf_pkg::ST_IDLE;
               kind_in  = mwuf_pkg::OUT_NONE;
            end
         end
         default: state_in = mwuf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.out_kind = kind_ff;
      case (state_ff)
         mwuf_pkg::ST_CLEAR: cmd.sweep_step = 1'b1;
         mwuf_pkg::ST_IDLE: begin
            cmd.req_ready   = 1'b1;
            cmd.accept      = req_valid;
            cmd.sweep_start = req_valid && !status.req_func;
         end
         mwuf_pkg::ST_PINIT: cmd.probe_init = 1'b1;
         mwuf_pkg::ST_PCHK: begin
            cmd.probe_step = !status.probe_free && !status.probe_exhausted;
         end
         mwuf_pkg::ST_MARK:    cmd.mark = 1'b1;
         mwuf_pkg::ST_DIV:     cmd.div_step = 1'b1;
         mwuf_pkg::ST_ADDR1:   cmd.addr1 = 1'b1;
         mwuf_pkg::ST_ADDR2:   cmd.addr2 = 1'b1;
         mwuf_pkg::ST_RA_INIT: cmd.root_init_a = 1'b1;
         mwuf_pkg::ST_RA_CHK: begin
            cmd.save_ra   = status.root_done;
            cmd.root_step = !status.root_done;
         end
         mwuf_pkg::ST_RB_INIT: cmd.root_init_b = 1'b1;
         mwuf_pkg::ST_RB_CHK: begin
            cmd.save_rb   = status.root_done;
            cmd.root_step = !status.root_done;
         end
         mwuf_pkg::ST_RKB: begin
            cmd.rank_sel_b = 1'b1;
            cmd.save_rka   = 1'b1;
         end
         mwuf_pkg::ST_UNITE: cmd.unite = 1'b1;
         mwuf_pkg::ST_DONE:  cmd.load_out = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

### hw/rtl/mwuf_datapath.sv
`timescale 1ns / 1ps

module mwuf_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  mwuf_pkg::cmd_type     cmd,
   output mwuf_pkg::status_type  status,
   input  logic                  req_func,
   input  logic [10:0]           req_start_edge,
   input  logic                  req_probe_down,
   input  logic                  csr_valid,
   input  logic                  csr_index,
   input  logic [5:0]            csr_data,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [10:0]           rsp_edge_index,
   output logic                  rsp_is_vertical,
   output logic [5:0]            rsp_wall_row,
   output logic [5:0]            rsp_wall_col,
   output logic                  rsp_wall_built,
   output logic                  rsp_all_used
);

   localparam int SW = mwuf_pkg::SIZE_W;
   localparam int EW = mwuf_pkg::EDGE_W;
   localparam int PW = mwuf_pkg::PT_W;

   // configuration and derived sizes
   logic [SW-1:0]   rows_ff, cols_ff, size_r_ff, size_c_ff, stride_ff;
   logic [SW-1:0]   size_r_in, size_c_in;
   logic [EW-1:0]   e_count_ff, nv_ff;
   logic [2*SW-1:0] rc;

   always_comb begin
      if (rows_ff < SW'(2))                        size_r_in = SW'(2);
      else if (32'(rows_ff) > mwuf_pkg::MAX_ROWS)  size_r_in = SW'(mwuf_pkg::MAX_ROWS);
      else                                         size_r_in = rows_ff;
      if (cols_ff < SW'(2))                          size_c_in = SW'(2);
      else if (32'(cols_ff) > mwuf_pkg::MAX_COLUMNS) size_c_in = SW'(mwuf_pkg::MAX_COLUMNS);
      else                                           size_c_in = cols_ff;
   end

   assign rc = size_r_ff * size_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= SW'(8);
         cols_ff <= SW'(8);
      end else if (csr_valid) begin
         if (csr_index == mwuf_pkg::CSR_GRID_ROWS) rows_ff <= csr_data;
         else                                      cols_ff <= csr_data;
      end
      size_r_ff  <= size_r_in;
      size_c_ff  <= size_c_in;
      stride_ff  <= size_c_ff + SW'(1);
      e_count_ff <= EW'({1'b0, rc, 1'b0} - (2*SW+2)'(size_r_ff) - (2*SW+2)'(size_c_ff));
      nv_ff      <= EW'(rc - (2*SW)'(size_r_ff));
   end

   // memories
   logic [PW-1:0]               parent_mem [mwuf_pkg::POINT_DEPTH];
   logic [mwuf_pkg::RANK_W-1:0] rank_mem   [mwuf_pkg::POINT_DEPTH];
   logic                        edge_mem   [mwuf_pkg::EDGE_DEPTH];
   logic [PW-1:0]               parent_q_ff;
   logic [mwuf_pkg::RANK_W-1:0] rank_q_ff;
   logic                        edge_q_ff;

   // clearing sweep
   logic [mwuf_pkg::CNT_W-1:0] cnt_ff;
   logic [PW-1:0]              sr_ff;
   logic [SW-1:0]              sc_ff;
   logic                       border_en_ff, border;

   assign border = border_en_ff && (sr_ff <= PW'(size_r_ff)) &&
                   (sr_ff == '0 || sr_ff == PW'(size_r_ff) || sc_ff == '0 || sc_ff == size_c_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         sr_ff        <= '0;
         sc_ff        <= '0;
         border_en_ff <= 1'b0;
      end else if (cmd.sweep_start) begin
         cnt_ff       <= '0;
         sr_ff        <= '0;
         sc_ff        <= '0;
         border_en_ff <= 1'b1;
      end else if (cmd.sweep_step) begin
         cnt_ff <= cnt_ff + mwuf_pkg::CNT_W'(1);
         if (sc_ff == size_c_ff) begin
            sc_ff <= '0;
            sr_ff <= sr_ff + PW'(1);
         end else begin
            sc_ff <= sc_ff + SW'(1);
         end
      end
   end

   // item, probe, divider, walk registers
   logic                  down_ff, vert_ff, built_ff;
   logic [EW-1:0]         start_ff, e_ff, n_ff, quo_ff;
   logic [SW-1:0]         rem_ff, div_ff, row_ff, col_ff;
   logic [mwuf_pkg::DIVC_W-1:0] dcnt_ff;
   logic [PW-1:0]         a_ff, b_ff, p_ff, ra_ff, rb_ff;
   logic [mwuf_pkg::STEP_W-1:0] steps_ff;
   logic [mwuf_pkg::RANK_W-1:0] rka_ff;
   logic [SW:0]           trial;
   logic                  fits;
   logic [EW-1:0]         e_last;

   assign e_last = e_count_ff - EW'(1);
   assign trial  = {rem_ff, quo_ff[EW-1]};
   assign fits   = trial >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         start_ff <= req_start_edge;
         down_ff  <= req_probe_down;
         built_ff <= 1'b0;
      end
      if (cmd.probe_init) begin
         e_ff <= (start_ff > e_last) ? e_last : start_ff;
         n_ff <= '0;
      end else if (cmd.probe_step) begin
         n_ff <= n_ff + EW'(1);
         if (down_ff) e_ff <= (e_ff == '0) ? e_last : e_ff - EW'(1);
         else         e_ff <= (e_ff == e_last) ? '0 : e_ff + EW'(1);
      end
      if (cmd.mark) begin
         vert_ff <= e_ff < nv_ff;
         quo_ff  <= (e_ff < nv_ff) ? e_ff : e_ff - nv_ff;
         div_ff  <= (e_ff < nv_ff) ? size_r_ff : size_c_ff;
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= fits ? SW'(trial - {1'b0, div_ff}) : SW'(trial);
         quo_ff  <= {quo_ff[EW-2:0], fits};
         dcnt_ff <= dcnt_ff + mwuf_pkg::DIVC_W'(1);
      end
      if (cmd.addr1) begin
         row_ff <= vert_ff ? rem_ff : SW'(quo_ff + EW'(1));
         col_ff <= vert_ff ? SW'(quo_ff + EW'(1)) : rem_ff;
      end
      if (cmd.addr2) a_ff <= PW'(row_ff * stride_ff + (2*SW)'(col_ff));
      if (cmd.root_init_a) begin
         b_ff     <= vert_ff ? a_ff + PW'(stride_ff) : a_ff + PW'(1);
         p_ff     <= a_ff;
         steps_ff <= '0;
      end else if (cmd.root_init_b) begin
         p_ff     <= b_ff;
         steps_ff <= '0;
      end else if (cmd.root_step) begin
         p_ff     <= parent_q_ff;
         steps_ff <= steps_ff + mwuf_pkg::STEP_W'(1);
      end
      if (cmd.save_ra)  ra_ff  <= p_ff;
      if (cmd.save_rb)  rb_ff  <= p_ff;
      if (cmd.save_rka) rka_ff <= rank_q_ff;
      if (cmd.unite)    built_ff <= 1'b1;
   end

   // memory ports
   always_ff @(posedge clock) begin
      edge_q_ff   <= edge_mem[e_ff[mwuf_pkg::EDGE_AW-1:0]];
      parent_q_ff <= parent_mem[p_ff];
      rank_q_ff   <= rank_mem[cmd.rank_sel_b ? rb_ff : ra_ff];
      if (cmd.sweep_step && 32'(cnt_ff) < mwuf_pkg::EDGE_DEPTH) begin
         edge_mem[cnt_ff[mwuf_pkg::EDGE_AW-1:0]] <= 1'b0;
      end else if (cmd.mark) begin
         edge_mem[e_ff[mwuf_pkg::EDGE_AW-1:0]] <= 1'b1;
      end
      if (cmd.sweep_step && 32'(cnt_ff) < mwuf_pkg::POINT_DEPTH) begin
         parent_mem[cnt_ff[PW-1:0]] <= border ? '0 : cnt_ff[PW-1:0];
         rank_mem[cnt_ff[PW-1:0]]   <= '0;
      end else if (cmd.unite) begin
         if (rka_ff < rank_q_ff) begin
            parent_mem[ra_ff] <= rb_ff;
         end else if (rank_q_ff < rka_ff) begin
            parent_mem[rb_ff] <= ra_ff;
         end else begin
            parent_mem[ra_ff] <= rb_ff;
            if (rank_q_ff != '1) rank_mem[rb_ff] <= rank_q_ff + mwuf_pkg::RANK_W'(1);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
      if (cmd.load_out) begin
         rsp_edge_index  <= '0;
         rsp_is_vertical <= 1'b0;
         rsp_wall_row    <= '0;
         rsp_wall_col    <= '0;
         rsp_wall_built  <= 1'b0;
         rsp_all_used    <= cmd.out_kind == mwuf_pkg::OUT_ALL_USED;
         if (cmd.out_kind == mwuf_pkg::OUT_WALL) begin
            rsp_edge_index  <= e_ff;
            rsp_is_vertical <= vert_ff;
            rsp_wall_row    <= row_ff;
            rsp_wall_col    <= col_ff;
            rsp_wall_built  <= built_ff;
         end
      end
   end

   always_comb begin
      status.req_func        = req_func;
      status.sweep_last      = cnt_ff == mwuf_pkg::CNT_W'(mwuf_pkg::SWEEP_LEN - 1);
      status.probe_free      = !edge_q_ff;
      status.probe_exhausted = n_ff == e_last;
      status.div_last        = dcnt_ff == mwuf_pkg::DIVC_W'(EW - 1);
      status.root_done       = steps_ff == mwuf_pkg::STEP_W'(mwuf_pkg::POINT_DEPTH) ||
                               32'(parent_q_ff) >= mwuf_pkg::POINT_DEPTH ||
                               parent_q_ff == p_ff;
      status.roots_equal     = ra_ff == p_ff;
      status.out_free        = !rsp_valid || rsp_ready;
   end

`ifndef SYNTHESIS
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || rsp_ready)) else $error("result overwritten");
   a_mark_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mark |-> (e_ff < e_count_ff)) else $error("probe left edge range");
   a_exhaust_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_all_used) |-> (rsp_edge_index == '0 && !rsp_wall_built))
      else $error("exhausted beat carries a wall");
`endif

endmodule
